// File: hdl/wasm_pkg.sv
// Package for the i32 stack executor: opcode and status codes, types, defaults.
// No dependencies; every other file of the block but wasm_div uses it.
`timescale 1ns / 1ps
package wasm_pkg;
  localparam int STACK_DEPTH_DEF = 1024;
  localparam int LOCAL_SLOTS_DEF = 64;

  typedef enum logic [4:0] {
    K_NOP = 5'd0, K_UNREACH = 5'd1, K_LGET = 5'd2, K_LSET = 5'd3, K_LTEE = 5'd4,
    K_CONST = 5'd5, K_EQ = 5'd6, K_NE = 5'd7, K_LTS = 5'd8, K_LTU = 5'd9,
    K_GTS = 5'd10, K_GTU = 5'd11, K_LES = 5'd12, K_ADD = 5'd13, K_SUB = 5'd14,
    K_MUL = 5'd15, K_DIVS = 5'd16, K_DIVU = 5'd17, K_REMS = 5'd18, K_REMU = 5'd19,
    K_BEGIN = 5'd20
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK = 3'd0, ST_TRAP = 3'd1, ST_UNDER = 3'd2, ST_OVER = 3'd3,
    ST_BADLOC = 3'd4, ST_DIVZERO = 3'd5, ST_SOVF = 3'd6
  } status_t;

  // Classified instruction handed from front to back.
  typedef struct packed {
    logic [4:0]  kind;
    logic [31:0] imm;
  } instr_t;

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_EXEC, S_DIV, S_WRITE
  } exec_state_t;
endpackage

// File: hdl/wasm_i32_stack_executor.sv
// Top level of the i32 stack executor: front end with queue, back end.
// Depends on wasm_pkg, wasm_fifo and wasm_backend.
// Instructions execute one at a time in the back end: stack memory read, execute
// (div/rem wait for the one-bit-per-cycle divider), write of the result register; the
// next one leaves the queue only when the output register is free or is taken that cycle.
// Reset (rst_n low, synchronous) empties stack and queue, clears locals valid bits.
`timescale 1ns / 1ps
module wasm_i32_stack_executor #(
  parameter int STACK_DEPTH = wasm_pkg::STACK_DEPTH_DEF,
  parameter int LOCAL_SLOTS = wasm_pkg::LOCAL_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [6:0]  cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // kind[4:0], immediate[36:5], zero pad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata   // status[2:0], top_value[34:3], stack_depth[45:35], pad
);
  logic [6:0] liu_r;
  logic full, empty, rd;
  wasm_pkg::instr_t qin, qout;

  always_ff @(posedge clk) begin
    if (!rst_n) liu_r <= 7'd0;
    else if (cfg_we) liu_r <= cfg_wdata;
  end

  // front end: unpack the transaction into the queue
  assign in_tready = !full;
  assign qin.kind  = in_tdata[4:0];
  assign qin.imm   = in_tdata[36:5];

  wasm_fifo u_fifo (
    .clk(clk), .rst_n(rst_n), .wr_en(in_tvalid && in_tready), .wr_data(qin),
    .full(full), .rd_en(rd), .rd_data(qout), .empty(empty)
  );

  wasm_backend #(.STACK_DEPTH(STACK_DEPTH), .LOCAL_SLOTS(LOCAL_SLOTS)) u_exec (
    .clk(clk), .rst_n(rst_n), .locals_in_use(liu_r), .q_empty(empty), .q_data(qout),
    .q_rd(rd), .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );
endmodule

// File: hdl/wasm_fifo.sv
// Two-entry instruction queue between the front end and the execute back end.
// Depends on wasm_pkg.
`timescale 1ns / 1ps
module wasm_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_en,
  input  wasm_pkg::instr_t wr_data,
  output logic            full,
  input  logic            rd_en,
  output wasm_pkg::instr_t rd_data,
  output logic            empty
);
  wasm_pkg::instr_t mem_r [2];
  logic wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign rd_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wp_r] <= wr_data;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (wr_en) wp_r <= ~wp_r;
      if (rd_en) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, wr_en} - {1'b0, rd_en};
    end
  end
endmodule

// File: hdl/wasm_div.sv
// Radix-2 restoring divider, one quotient bit per cycle, signed and unsigned.
// No package dependencies.
`timescale 1ns / 1ps
module wasm_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        sgn,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic        done,
  output logic [31:0] quo,
  output logic [31:0] rem
);
  logic [31:0] q_r, r_r, d_r;
  logic [5:0]  cnt_r;
  logic        busy_r, nq_r, nr_r;
  logic [32:0] trial;

  assign trial = {r_r, q_r[31]} - {1'b0, d_r};
  assign quo   = nq_r ? (~q_r + 32'd1) : q_r;
  assign rem   = nr_r ? (~r_r + 32'd1) : r_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done <= 1'b0; cnt_r <= 6'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 6'd32;
        r_r    <= 32'd0;
        q_r    <= (sgn && a[31]) ? (~a + 32'd1) : a;
        d_r    <= (sgn && b[31]) ? (~b + 32'd1) : b;
        nq_r   <= sgn && (a[31] ^ b[31]);
        nr_r   <= sgn && a[31];
      end else if (busy_r) begin
        // shift in one dividend bit, subtract when it fits
        if (!trial[32]) begin
          r_r <= trial[31:0];
          q_r <= {q_r[30:0], 1'b1};
        end else begin
          r_r <= {r_r[30:0], q_r[31]};
          q_r <= {q_r[30:0], 1'b0};
        end
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end
endmodule

// File: hdl/wasm_exec.sv
// Execute back end: operand stack memory, locals file, ALU sequencing, result register.
// Depends on wasm_pkg and wasm_div.
`timescale 1ns / 1ps
module wasm_backend #(
  parameter int STACK_DEPTH = wasm_pkg::STACK_DEPTH_DEF,
  parameter int LOCAL_SLOTS = wasm_pkg::LOCAL_SLOTS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [6:0]       locals_in_use,
  input  logic             q_empty,
  input  wasm_pkg::instr_t q_data,
  output logic             q_rd,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [47:0]      out_tdata
);
  localparam int SPW = $clog2(STACK_DEPTH + 1);
  localparam int AW  = $clog2(STACK_DEPTH);
  localparam int LW  = (LOCAL_SLOTS > 1) ? $clog2(LOCAL_SLOTS) : 1;

  wasm_pkg::exec_state_t state_r, state_nxt;
  wasm_pkg::instr_t ins_r;
  logic [SPW-1:0] sp_r, sp_nxt;
  logic [31:0] top_r, top_nxt, sec_r;   // cached top entry, fetched second
  logic [31:0] loc_mem [LOCAL_SLOTS];
  logic [LOCAL_SLOTS-1:0] lvalid_r, lvalid_nxt;
  logic [31:0] stk_mem [STACK_DEPTH];
  logic [31:0] stk_rd;
  logic        stk_we;
  logic [AW-1:0] stk_wa, stk_ra;
  logic [31:0] stk_wd;
  logic        loc_we;
  logic [31:0] loc_rd_q;
  logic [2:0]  st_r, st_nxt;
  logic        ov_r, ov_nxt;
  logic        div_start, div_done;
  logic [31:0] quo, rem;
  logic [31:0] a, b, res;
  logic        lok, bin;
  logic [10:0] lim;
  logic [31:0] lidx_w;
  logic [LW-1:0] lidx;
  logic [47:0] rslt;

  // locals bound and index
  always_comb begin
    lim    = ({4'd0, locals_in_use} > 11'(LOCAL_SLOTS)) ? 11'(LOCAL_SLOTS)
                                                        : {4'd0, locals_in_use};
    lok    = ins_r.imm < {21'd0, lim};
    lidx_w = ins_r.imm;
    lidx   = lidx_w[LW-1:0];
  end

  // stack memory, registered read
  always_ff @(posedge clk) begin
    if (stk_we) stk_mem[stk_wa] <= stk_wd;
    stk_rd <= stk_mem[stk_ra];
  end

  // locals storage; valid bits give the zero reset
  always_ff @(posedge clk) begin
    if (loc_we) loc_mem[lidx] <= top_r;
    loc_rd_q <= loc_mem[lidx];
  end

  wasm_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start),
    .sgn(ins_r.kind == wasm_pkg::K_DIVS || ins_r.kind == wasm_pkg::K_REMS),
    .a(sec_r), .b(top_r), .done(div_done), .quo(quo), .rem(rem)
  );

  assign a = sec_r;
  assign b = top_r;

  // simple two-operand ALU
  always_comb begin
    case (ins_r.kind)
      wasm_pkg::K_EQ:  res = {31'd0, a == b};
      wasm_pkg::K_NE:  res = {31'd0, a != b};
      wasm_pkg::K_LTS: res = {31'd0, $signed(a) < $signed(b)};
      wasm_pkg::K_LTU: res = {31'd0, a < b};
      wasm_pkg::K_GTS: res = {31'd0, $signed(a) > $signed(b)};
      wasm_pkg::K_GTU: res = {31'd0, a > b};
      wasm_pkg::K_LES: res = {31'd0, $signed(a) <= $signed(b)};
      wasm_pkg::K_ADD: res = a + b;
      wasm_pkg::K_SUB: res = a - b;
      wasm_pkg::K_MUL: res = a * b;
      wasm_pkg::K_DIVS, wasm_pkg::K_DIVU: res = quo;
      default:         res = (b == 32'hFFFF_FFFF && ins_r.kind == wasm_pkg::K_REMS) ? 32'd0 : rem;
    endcase
  end

  assign bin = ins_r.kind inside {[wasm_pkg::K_EQ : wasm_pkg::K_REMU]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= wasm_pkg::S_IDLE;
      sp_r     <= '0;
      lvalid_r <= '0;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      sp_r     <= sp_nxt;
      lvalid_r <= lvalid_nxt;
      ov_r     <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    top_r <= top_nxt;
    st_r  <= st_nxt;
    if (q_rd) ins_r <= q_data;
    if (state_r == wasm_pkg::S_READ) sec_r <= stk_rd;
  end

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    sp_nxt     = sp_r;
    top_nxt    = top_r;
    lvalid_nxt = lvalid_r;
    st_nxt     = st_r;
    ov_nxt     = ov_r;
    q_rd       = 1'b0;
    stk_we     = 1'b0;
    stk_wa     = sp_r[AW-1:0];
    stk_wd     = top_r;
    stk_ra     = AW'(sp_r - SPW'(2));
    loc_we     = 1'b0;
    div_start  = 1'b0;
    case (state_r)
      wasm_pkg::S_IDLE: begin
        if (!q_empty && !ov_r) begin
          q_rd      = 1'b1;
          state_nxt = wasm_pkg::S_READ;
        end
        if (ov_r && out_tready) ov_nxt = 1'b0;
        if (!q_empty && ov_r && out_tready) begin
          q_rd      = 1'b1;
          state_nxt = wasm_pkg::S_READ;
        end
      end
      wasm_pkg::S_READ: begin
        // stack entry below the top and the local arrive next cycle
        state_nxt = wasm_pkg::S_EXEC;
      end
      wasm_pkg::S_EXEC: begin
        state_nxt = wasm_pkg::S_WRITE;
        st_nxt    = wasm_pkg::ST_OK;
        case (ins_r.kind)
          wasm_pkg::K_NOP: ;
          wasm_pkg::K_LGET: begin
            if (!lok) st_nxt = wasm_pkg::ST_BADLOC;
            else if (sp_r >= SPW'(STACK_DEPTH)) st_nxt = wasm_pkg::ST_OVER;
            else begin
              if (sp_r != '0) begin stk_we = 1'b1; stk_wa = AW'(sp_r - SPW'(1)); end
              top_nxt = lvalid_r[lidx] ? loc_rd_q : 32'd0;
              sp_nxt  = sp_r + SPW'(1);
            end
          end
          wasm_pkg::K_LSET, wasm_pkg::K_LTEE: begin
            if (!lok) st_nxt = wasm_pkg::ST_BADLOC;
            else if (sp_r == '0) st_nxt = wasm_pkg::ST_UNDER;
            else begin
              loc_we = 1'b1;
              lvalid_nxt[lidx] = 1'b1;
              if (ins_r.kind == wasm_pkg::K_LSET) begin
                sp_nxt  = sp_r - SPW'(1);
                top_nxt = sec_r;
              end
            end
          end
          wasm_pkg::K_CONST: begin
            if (sp_r >= SPW'(STACK_DEPTH)) st_nxt = wasm_pkg::ST_OVER;
            else begin
              if (sp_r != '0) begin stk_we = 1'b1; stk_wa = AW'(sp_r - SPW'(1)); end
              top_nxt = ins_r.imm;
              sp_nxt  = sp_r + SPW'(1);
            end
          end
          wasm_pkg::K_BEGIN: begin
            sp_nxt     = '0;
            lvalid_nxt = '0;
          end
          default: begin
            if (!bin) st_nxt = wasm_pkg::ST_TRAP;
            else if (sp_r < SPW'(2)) st_nxt = wasm_pkg::ST_UNDER;
            else if (ins_r.kind inside {[wasm_pkg::K_DIVS : wasm_pkg::K_REMU]}) begin
              if (b == 32'd0) st_nxt = wasm_pkg::ST_DIVZERO;
              else if (ins_r.kind == wasm_pkg::K_DIVS && a == 32'h8000_0000
                       && b == 32'hFFFF_FFFF) st_nxt = wasm_pkg::ST_SOVF;
              else begin
                div_start = 1'b1;
                state_nxt = wasm_pkg::S_DIV;
              end
            end else begin
              top_nxt = res;
              sp_nxt  = sp_r - SPW'(1);
            end
          end
        endcase
      end
      wasm_pkg::S_DIV: begin
        if (div_done) begin
          top_nxt   = res;
          sp_nxt    = sp_r - SPW'(1);
          state_nxt = wasm_pkg::S_WRITE;
        end
      end
      default: begin
        // result into the output register
        ov_nxt    = 1'b1;
        state_nxt = wasm_pkg::S_IDLE;
      end
    endcase
  end

  // top of stack after a pop comes from the cached second entry or the ALU result, with no re-read
  assign rslt = {2'd0, 11'(sp_r), (sp_r == '0) ? 32'd0 : top_r, st_r};

  always_ff @(posedge clk) begin
    if (state_r == wasm_pkg::S_WRITE) out_tdata <= rslt;
  end
  assign out_tvalid = ov_r;
endmodule

// File: hdl/wasm_checker.sv
// Port-level checker for the i32 stack executor, bound to the top level.
// Depends on wasm_pkg.
`timescale 1ns / 1ps
module wasm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)) else $error("out held");
  a_stat: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[2:0] <= wasm_pkg::ST_SOVF) else $error("bad status");
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[45:35] == 11'd0 |-> out_tdata[34:3] == 32'd0)
    else $error("empty stack top");
  // input ready (queue not full) and no result pending straight after reset
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_tvalid && in_tready)
    else $error("reset");
endmodule

bind wasm_i32_stack_executor wasm_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
);

// File: bench/tb.sv
// Self-checking bench for wasm_i32_stack_executor: random and directed i32 instructions.
// Depends on wasm_pkg and the executor RTL; predicts every result in-bench.
`timescale 1ns / 1ps
module tb;
  localparam int DEPTH = wasm_pkg::STACK_DEPTH_DEF;
  localparam int SLOTS = wasm_pkg::LOCAL_SLOTS_DEF;

  // same bit order as out_tdata[45:0]
  typedef struct packed {
    logic [10:0] depth;
    logic [31:0] top;
    logic [2:0]  status;
  } res_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [6:0]  cfg_wdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic        in_tready_q = 1'b0;

  wasm_i32_stack_executor dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  // Predictor state
  logic [31:0] m_stack [DEPTH];
  int unsigned m_sp;
  logic [31:0] m_locals [SLOTS];
  logic [6:0]  m_nloc;

  logic [39:0] pending_instrs [$];
  res_t        expected_results [$];
  int          errors = 0;
  int          n_checked = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          hold_cycles = 0;
  bit          hold_req = 1'b0;

  initial forever #1 clk = ~clk;

  function automatic bit slt(logic [31:0] a, logic [31:0] b);
    return $signed(a) < $signed(b);
  endfunction

  // Execute one instruction on the predictor, return the expected result
  function automatic res_t execute_instr(logic [4:0] kind, logic [31:0] imm);
    res_t r;
    logic [2:0] st;
    logic [31:0] a, b, v;
    int unsigned lim;
    st = wasm_pkg::ST_OK;
    lim = (m_nloc > SLOTS) ? SLOTS : m_nloc;
    v = '0;
    case (kind)
      wasm_pkg::K_NOP: ;
      wasm_pkg::K_LGET: begin
        if (imm >= lim) st = wasm_pkg::ST_BADLOC;
        else if (m_sp >= DEPTH) st = wasm_pkg::ST_OVER;
        else begin
          m_stack[m_sp] = m_locals[imm]; m_sp++;
        end
      end
      wasm_pkg::K_LSET, wasm_pkg::K_LTEE: begin
        if (imm >= lim) st = wasm_pkg::ST_BADLOC;
        else if (m_sp == 0) st = wasm_pkg::ST_UNDER;
        else begin
          m_locals[imm] = m_stack[m_sp-1];
          if (kind == wasm_pkg::K_LSET) m_sp--;
        end
      end
      wasm_pkg::K_CONST: begin
        if (m_sp >= DEPTH) st = wasm_pkg::ST_OVER;
        else begin
          m_stack[m_sp] = imm; m_sp++;
        end
      end
      wasm_pkg::K_BEGIN: begin
        m_sp = 0;
        for (int i = 0; i < SLOTS; i++) m_locals[i] = '0;
      end
      default: begin
        if (kind >= wasm_pkg::K_EQ && kind <= wasm_pkg::K_REMU) begin
          if (m_sp < 2) st = wasm_pkg::ST_UNDER;
          else begin
            a = m_stack[m_sp-2];
            b = m_stack[m_sp-1];
            case (kind)
              wasm_pkg::K_EQ:  v = 32'(a == b);
              wasm_pkg::K_NE:  v = 32'(a != b);
              wasm_pkg::K_LTS: v = 32'(slt(a, b));
              wasm_pkg::K_LTU: v = 32'(a < b);
              wasm_pkg::K_GTS: v = 32'(slt(b, a));
              wasm_pkg::K_GTU: v = 32'(a > b);
              wasm_pkg::K_LES: v = 32'(!slt(b, a));
              wasm_pkg::K_ADD: v = a + b;
              wasm_pkg::K_SUB: v = a - b;
              wasm_pkg::K_MUL: v = a * b;
              wasm_pkg::K_DIVS: begin
                if (b == 0) st = wasm_pkg::ST_DIVZERO;
                else if (a == 32'h8000_0000 && b == '1) st = wasm_pkg::ST_SOVF;
                else v = $signed(a) / $signed(b);
              end
              wasm_pkg::K_DIVU: if (b == 0) st = wasm_pkg::ST_DIVZERO; else v = a / b;
              wasm_pkg::K_REMS: begin
                if (b == 0) st = wasm_pkg::ST_DIVZERO;
                else if (b == '1) v = '0;
                else v = $signed(a) % $signed(b);
              end
              default: if (b == 0) st = wasm_pkg::ST_DIVZERO; else v = a % b;
            endcase
            if (st == wasm_pkg::ST_OK) begin
              m_stack[m_sp-2] = v; m_sp--;
            end
          end
        end else st = wasm_pkg::ST_TRAP;
      end
    endcase
    r.status = st;
    r.top = (m_sp > 0) ? m_stack[m_sp-1] : '0;
    r.depth = 11'(m_sp);
    return r;
  endfunction

  function automatic logic [39:0] pack_instr(logic [4:0] kind, logic [31:0] imm);
    return {3'b0, imm, kind};
  endfunction

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'(int'($urandom_range(0, 8)) - 4);
      3: return 32'h7FFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Random instruction, mostly well formed for a stack at predicted depth
  function automatic logic [39:0] rand_instr(int unsigned depth_hint);
    logic [4:0] k;
    logic [31:0] imm;
    int sel;
    sel = $urandom_range(0, 99);
    imm = rand_value();
    if (sel < 30 || depth_hint < 2) k = wasm_pkg::K_CONST;
    else if (sel < 60) k = 5'($urandom_range(wasm_pkg::K_EQ, wasm_pkg::K_REMU));
    else if (sel < 80) begin
      k = 5'($urandom_range(wasm_pkg::K_LGET, wasm_pkg::K_LTEE));
      imm = ($urandom_range(0, 9) == 0) ? $urandom : 32'($urandom_range(0, 70));
    end else if (sel < 88) k = 5'($urandom_range(0, 1));
    else if (sel < 92) k = wasm_pkg::K_BEGIN;
    else if (sel < 96) k = 5'($urandom_range(21, 31));
    else k = 5'($urandom_range(0, 31));
    return pack_instr(k, imm);
  endfunction

  // Driver: changes at falling edge
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_tvalid || in_tready_q) begin
        if (pending_instrs.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_tdata  <= pending_instrs.pop_front();
          in_tvalid <= 1'b1;
        end else in_tvalid <= 1'b0;
      end
      if (hold_req) begin
        out_tready <= 1'b0;
      end else out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Accept flag sampled at the rising edge so the driver knows the item left
  always @(posedge clk) in_tready_q <= in_tvalid && in_tready;

  // Predict on input acceptance
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready)
      expected_results.push_back(execute_instr(in_tdata[4:0], in_tdata[36:5]));
  end

  // Monitor
  always @(posedge clk) begin
    res_t got, exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[45:0];
      if (expected_results.size() == 0) begin
        $display("%0t: result with none expected: %h", $realtime, got);
        errors++;
      end else begin
        exp_r = expected_results.pop_front();
        n_checked++;
        if (got.status !== exp_r.status)
          $display("%0t: status exp %0d got %0d", $realtime, exp_r.status, got.status);
        if (got.top !== exp_r.top)
          $display("%0t: top_value exp %h got %h", $realtime, exp_r.top, got.top);
        if (got.depth !== exp_r.depth)
          $display("%0t: stack_depth exp %0d got %0d", $realtime, exp_r.depth, got.depth);
        if (got !== exp_r) errors++;
      end
    end
  end

  // Long receiver hold, counted in cycles
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      if (hold_cycles == 1) hold_req <= 1'b0;
    end
  end

  task automatic drain();
    while (pending_instrs.size() > 0 || in_tvalid || expected_results.size() > 0)
      @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_cfg(logic [6:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    m_nloc = v;
  endtask

  task automatic random_phase(int n);
    int unsigned d;
    logic [39:0] it;
    d = m_sp;
    for (int i = 0; i < n; i++) begin
      it = rand_instr(d);
      pending_instrs.push_back(it);
      // rough depth tracking for shaping only
      case (it[4:0])
        wasm_pkg::K_CONST, wasm_pkg::K_LGET: d++;
        wasm_pkg::K_LSET: if (d > 0) d--;
        wasm_pkg::K_BEGIN: d = 0;
        default: if (it[4:0] >= wasm_pkg::K_EQ && it[4:0] <= wasm_pkg::K_REMU && d > 1) d--;
      endcase
    end
  endtask

  initial begin
    m_sp = 0;
    m_nloc = '0;
    for (int i = 0; i < SLOTS; i++) m_locals[i] = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part with no locals first
    send_idle_pct = 0; recv_idle_pct = 0;
    pending_instrs.push_back(pack_instr(wasm_pkg::K_NOP, 32'h0));
    pending_instrs.push_back(pack_instr(wasm_pkg::K_ADD, 32'h0));       // underflow
    pending_instrs.push_back(pack_instr(wasm_pkg::K_LSET, 32'h0));      // bad local
    pending_instrs.push_back(pack_instr(wasm_pkg::K_UNREACH, 32'hFFFF_FFFF));
    pending_instrs.push_back(pack_instr(5'd31, 32'h1234));              // unused kind
    drain();
    write_cfg(7'd64);
    pending_instrs.push_back(pack_instr(wasm_pkg::K_LTEE, 32'd0));      // underflow
    pending_instrs.push_back(pack_instr(wasm_pkg::K_LGET, 32'd64));     // bad local
    pending_instrs.push_back(pack_instr(wasm_pkg::K_LGET, 32'hFFFF_FFFF));
    pending_instrs.push_back(pack_instr(wasm_pkg::K_CONST, 32'h8000_0000));
    pending_instrs.push_back(pack_instr(wasm_pkg::K_CONST, 32'hFFFF_FFFF));
    pending_instrs.push_back(pack_instr(wasm_pkg::K_LTEE, 32'd63));
    pending_instrs.push_back(pack_instr(wasm_pkg::K_DIVS, 32'h0));      // signed overflow
    pending_instrs.push_back(pack_instr(wasm_pkg::K_REMS, 32'h0));      // min rem -1 -> 0
    pending_instrs.push_back(pack_instr(wasm_pkg::K_CONST, 32'h0));
    pending_instrs.push_back(pack_instr(wasm_pkg::K_DIVU, 32'h0));      // divide by zero
    pending_instrs.push_back(pack_instr(wasm_pkg::K_REMU, 32'h0));
    pending_instrs.push_back(pack_instr(wasm_pkg::K_LGET, 32'd63));
    pending_instrs.push_back(pack_instr(wasm_pkg::K_LES, 32'h0));
    pending_instrs.push_back(pack_instr(wasm_pkg::K_BEGIN, 32'h0));
    pending_instrs.push_back(pack_instr(wasm_pkg::K_LGET, 32'd63));
    drain();

    // Fill the stack to overflow, with receiver held off to stall the input
    hold_req = 1'b1; hold_cycles = 3000;
    for (int i = 0; i < DEPTH + 2; i++)
      pending_instrs.push_back(pack_instr(wasm_pkg::K_CONST, $urandom));
    pending_instrs.push_back(pack_instr(wasm_pkg::K_LGET, 32'd5));
    drain();
    pending_instrs.push_back(pack_instr(wasm_pkg::K_BEGIN, 32'h0));
    drain();

    // Random phases over several register values and idle mixes
    write_cfg(7'd127);
    send_idle_pct = 6; recv_idle_pct = 64;
    random_phase(200);
    drain();
    write_cfg(7'd1);
    random_phase(100);
    drain();
    write_cfg(7'($urandom_range(2, 63)));
    send_idle_pct = 64; recv_idle_pct = 6;
    random_phase(200);
    drain();
    write_cfg(7'd0);
    random_phase(50);
    drain();
    write_cfg(7'd64);
    send_idle_pct = 0; recv_idle_pct = 0;
    random_phase(250);
    drain();

    $display("covered %0d checked results: all kinds, all statuses, stack fill to overflow,",
             n_checked);
    $display("locals limits 0/1/64/127 and three idle mixes");
    if (errors == 0 && expected_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end
endmodule
